FILE: src/rcl_pkg.sv
// Shared types and constants for the RIFF chunk locator.
package rcl_pkg;

    localparam logic [31:0] RIFF_ID = 32'h5249_4646;

    typedef enum logic [1:0] {
        PH_ID     = 2'd0,
        PH_SIZE   = 2'd1,
        PH_FORMAT = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_MALFORMED = 2'd3
    } status_t;

    typedef struct packed {
        logic [30:0] size;
        logic [31:0] offset;
        status_t     status;
    } result_t;

endpackage

FILE: src/riff_chunk_locator_core.sv
// Top level of the RIFF chunk locator: input stage, scanner and output buffer.
//
// The block takes a RIFF file one byte per item on the s_ channel, with s_tlast
// on the final byte, and searches for the first chunk whose four-character id
// equals the search id written through cfg_wr_en / cfg_wr_data (first character
// in bits 31..24; it resets to 'RIFF'). RIFF chunks that do not match are
// descended into, up to MAX_DEPTH nested regions; other chunks are skipped.
// Each file yields exactly one result item on the m_ channel: found with the
// data offset and size, not found, truncated header at top level, or malformed
// size. The result appears on the byte that completes the deciding header, or
// on the last byte; bytes after a decision are consumed until s_tlast.
// Throughput is one byte per cycle while s_tready is high: every byte is settled
// by one pass of the scanner logic between the input register and the output
// register. A result is valid on m_ once it reaches the output register.
// The output holds two result items (output register plus skid entry); only
// when both are full and a byte waits in the input register does s_tready drop.
// Reset (aresetn low at a clock edge) clears the scanner to the start of a file,
// empties both buffers and restores the search id.
module riff_chunk_locator_core import rcl_pkg::*; #(
    parameter int MAX_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata      // [1:0] status, [33:2] chunk_offset,
                                     // [64:34] body_length, [71:65] zero
);

    logic [31:0] search_id_reg;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        m_valid_reg, m_valid_next;
    result_t     m_res_reg, m_res_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_res_reg, skid_res_next;

    logic        s_accept;
    logic        proc_go;
    logic        m_pop;
    logic        res_valid;
    result_t     res;

    // A byte moves into the scanner whenever the skid entry is free, so a result
    // it produces always has somewhere to go.
    assign proc_go  = in_valid_reg && !skid_valid_reg;
    assign s_tready = !in_valid_reg || !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_id_reg <= RIFF_ID;
        end else if (cfg_wr_en) begin
            search_id_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_go) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rcl_scanner #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (proc_go),
        .step_byte (in_byte_reg),
        .step_last (in_last_reg),
        .search_id (search_id_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Two-entry output: a new result lands in the output register when it is
    // free or draining, otherwise in the skid entry.
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_res_next      = m_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (m_pop) begin
            m_valid_next    = skid_valid_reg;
            m_res_next      = skid_res_reg;
            skid_valid_next = 1'b0;
        end
        if (res_valid) begin
            if (!m_valid_reg || m_pop) begin
                m_valid_next = 1'b1;
                m_res_next   = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_res_next   = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg    <= m_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg.size, m_res_reg.offset, m_res_reg.status};

    // The skid entry is only ever filled behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // A byte held in the input stage is not lost while the buffers are full.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && skid_valid_reg) |=> (in_valid_reg && $stable(in_byte_reg)
                                              && $stable(in_last_reg)))
        else $error("stalled input byte was dropped or changed");

    // Only a found chunk carries an offset and size.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_res_reg.status != ST_FOUND) |->
            (m_res_reg.offset == 32'd0 && m_res_reg.size == 31'd0))
        else $error("non-found result carries offset or size");

    // The scanner never produces a result while the skid entry is occupied.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !skid_valid_reg)
        else $error("result produced with no free output entry");

endmodule

FILE: src/rcl_scanner.sv
// Chunk header scanner: per-byte state update, region stack and result decision.
module rcl_scanner import rcl_pkg::*; #(
    parameter int MAX_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic [7:0]  step_byte,
    input  logic        step_last,
    input  logic [31:0] search_id,
    output logic        res_valid,
    output result_t     res
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    phase_t               phase_reg, phase_next;
    logic [1:0]           fbc_reg, fbc_next;
    logic [31:0]          id_reg, id_next;
    logic [31:0]          size_reg, size_next;
    logic [31:0]          body_reg, body_next;
    logic [31:0]          skip_reg, skip_next;
    logic [31:0]          npos_reg, npos_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic                 done_reg, done_next;
    logic [31:0]          stack_reg [MAX_DEPTH];

    logic                 push_en;
    logic [31:0]          push_val;

    always_comb begin
        logic [31:0]        size_new;
        logic [31:0]        lim;
        logic [32:0]        end_sum;
        logic [31:0]        entry;
        logic [DEPTH_W-1:0] nd;
        logic               emit;
        logic               clear;
        logic               cut;

        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        id_next    = id_reg;
        size_next  = size_reg;
        body_next  = body_reg;
        skip_next  = skip_reg;
        npos_next  = npos_reg;
        depth_next = depth_reg;
        done_next  = done_reg;
        push_en    = 1'b0;
        push_val   = npos_reg;
        res_valid  = 1'b0;
        res        = '{size: '0, offset: '0, status: ST_NOT_FOUND};
        emit       = 1'b0;
        clear      = 1'b0;
        cut        = 1'b0;
        nd         = '0;
        entry      = '0;
        size_new   = {step_byte, size_reg[31:8]};

        // Limit for a new region: end of the enclosing one, or the top of the space.
        lim = 32'hFFFF_FFFF;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (DEPTH_W'(i + 1) == depth_reg) lim = stack_reg[i];
        end
        end_sum = {1'b0, npos_reg} + {1'b0, body_reg};

        if (step_en) begin
            if (done_reg) begin
                clear = step_last;
            end else begin
                npos_next = npos_reg + 32'd1;
                unique case (phase_reg)
                    PH_ID: begin
                        id_next = {id_reg[23:0], step_byte};
                        fbc_next = fbc_reg + 2'd1;
                        if (fbc_reg == 2'd3) phase_next = PH_SIZE;
                    end
                    PH_SIZE: begin
                        size_next = size_new;
                        body_next = (size_new >= 32'd4) ? size_new - 32'd4 : 32'd0;
                        fbc_next  = fbc_reg + 2'd1;
                        if (fbc_reg == 2'd3) begin
                            if (size_new[31]) begin
                                emit = 1'b1;
                                res.status = ST_MALFORMED;
                            end else if (id_reg == search_id) begin
                                emit = 1'b1;
                                res  = '{size: size_new[30:0], offset: npos_reg,
                                         status: ST_FOUND};
                            end else if (id_reg == RIFF_ID) begin
                                phase_next = PH_FORMAT;
                            end else if (size_new != 32'd0) begin
                                skip_next  = size_new;
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_ID;
                            end
                        end
                    end
                    PH_FORMAT: begin
                        fbc_next = fbc_reg + 2'd1;
                        if (fbc_reg == 2'd3) begin
                            if (depth_reg < DEPTH_W'(MAX_DEPTH)) begin
                                push_en    = 1'b1;
                                push_val   = (end_sum > {1'b0, lim}) ? lim : end_sum[31:0];
                                depth_next = depth_reg + DEPTH_W'(1);
                                phase_next = PH_ID;
                            end else if (body_reg != 32'd0) begin
                                skip_next  = body_reg;
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_ID;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (skip_reg != 32'd0) skip_next = skip_reg - 32'd1;
                        if (skip_reg <= 32'd1) phase_next = PH_ID;
                    end
                    default: phase_next = PH_ID;
                endcase

                // Close every region that ends on this byte; ends only shrink inward,
                // so the matching entries form the top of the stack.
                if (!emit) begin
                    for (int i = 0; i < MAX_DEPTH; i++) begin
                        entry = (push_en && DEPTH_W'(i) == depth_reg) ? push_val
                                                                      : stack_reg[i];
                        if (DEPTH_W'(i) < depth_next && entry != npos_reg) begin
                            nd = DEPTH_W'(i + 1);
                        end
                    end
                    if (nd != depth_next) begin
                        depth_next = nd;
                        phase_next = PH_ID;
                        fbc_next   = 2'd0;
                        skip_next  = 32'd0;
                    end
                end

                if (step_last) begin
                    if (!emit) begin
                        cut = (depth_next == '0) &&
                              (phase_next == PH_SIZE || phase_next == PH_FORMAT ||
                               (phase_next == PH_ID && fbc_next != 2'd0));
                        emit = 1'b1;
                        res.status = cut ? ST_TRUNCATED : ST_NOT_FOUND;
                    end
                    clear = 1'b1;
                end else if (emit) begin
                    done_next = 1'b1;
                end
            end
        end

        res_valid = emit;

        if (clear) begin
            phase_next = PH_ID;
            fbc_next   = 2'd0;
            id_next    = '0;
            size_next  = '0;
            body_next  = '0;
            skip_next  = '0;
            npos_next  = 32'd1;
            depth_next = '0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ID;
            fbc_reg   <= 2'd0;
            id_reg    <= '0;
            size_reg  <= '0;
            body_reg  <= '0;
            skip_reg  <= '0;
            npos_reg  <= 32'd1;
            depth_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            id_reg    <= id_next;
            size_reg  <= size_next;
            body_reg  <= body_next;
            skip_reg  <= skip_next;
            npos_reg  <= npos_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
        end
    end

    // Region ends are only read below the current depth, so they need no reset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (push_en && DEPTH_W'(i) == depth_reg) stack_reg[i] <= push_val;
        end
    end

endmodule
